[sv/cddn_pkg.sv]
// ----------------------------------------------------------------------------
// cddn_pkg - calendar date / day number converter package
// Shared constants, month tables and year arithmetic helpers. Divisions of
// a year by 100 and of a day number by 366 are done by reciprocal multiply.
// ----------------------------------------------------------------------------
package cddn_pkg;

	localparam int unsigned EPOCH_YEAR_DEF = 1996;
	localparam int unsigned LAST_YEAR_DEF  = 2050;

	localparam int unsigned MONTHS_PER_YEAR = 12;
	localparam logic [3:0]  FEB             = 4'd2;
	localparam logic [8:0]  DAYS_PER_YEAR   = 9'd365;

	// floor(x / 100) = (x * 5243) >> 19, exact for any 14-bit x
	localparam logic [12:0] DIV100_MUL = 13'd5243;
	// floor(s / 366) = (s * 45840) >> 24, exact for any 16-bit s
	localparam logic [15:0] DIV366_MUL = 16'd45840;

	// request codes
	typedef enum logic {
		REQ_DATE_TO_SERIAL = 1'b0,
		REQ_SERIAL_TO_DATE = 1'b1
	} req_kind_t;

	typedef logic [13:0] year_t;
	typedef logic [7:0]  cent_t;

	typedef struct packed {
		logic [3:0] month;
		logic [4:0] day;
	} month_day_t;

	// days before the first of each month in a common year, indexed by month
	localparam logic [8:0] CUM_DAYS [16] = '{
		9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
		9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0, 9'd0, 9'd0
	};

	// month lengths in a common year, indexed by month
	localparam logic [4:0] MONTH_DAYS [16] = '{
		5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
		5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
	};

	// century number of a year
	function automatic cent_t div100(input year_t x);
		logic [26:0] p;
		p = 27'(x) * 27'(DIV100_MUL);
		return p[26:19];
	endfunction

	// century number divided by 40, for century numbers below 120 (millennium groups of 4000 years)
	function automatic logic [1:0] cent_div40(input cent_t q);
		if (q >= 8'd80)
			return 2'd2;
		else if (q >= 8'd40)
			return 2'd1;
		return 2'd0;
	endfunction

	function automatic cent_t cent_mod40(input cent_t q);
		return q - 8'(cent_div40(q)) * 8'd40;
	endfunction

	function automatic logic [6:0] mod100(input year_t x, input cent_t q);
		logic [14:0] t;
		t = 15'(q) * 15'd100;
		return 7'(x - t[13:0]);
	endfunction

	// leap: by 4, not by 4000, and by 400 or not by 100
	function automatic logic is_leap(input year_t x, input cent_t q);
		if (mod100(x, q) != 7'd0)
			return (x[1:0] == 2'b00);
		return (q[1:0] == 2'b00) && (cent_mod40(q) != 8'd0);
	endfunction

	// number of leap years in 1..x
	function automatic logic [11:0] leap_count(input year_t x, input cent_t q);
		return 12'(x >> 2) - 12'(q) + 12'(q >> 2) - 12'(cent_div40(q));
	endfunction

	function automatic logic [8:0] days_before_month(input logic [3:0] m, input logic leap);
		return CUM_DAYS[m] + ((leap && (m > FEB)) ? 9'd1 : 9'd0);
	endfunction

	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		return MONTH_DAYS[m] + ((leap && (m == FEB)) ? 5'd1 : 5'd0);
	endfunction

endpackage

[sv/cddn_req_if.sv]
// ----------------------------------------------------------------------------
// cddn_req_if - request channel
// Valid/ready channel carrying one conversion request per transaction.
// ----------------------------------------------------------------------------
interface cddn_req_if;

	logic               valid;
	logic               ready;
	logic               req_type;
	logic [13:0]        year_in;
	logic [6:0]         month_in;
	logic [6:0]         day_in;
	logic signed [15:0] serial_in;
	logic signed [15:0] offset_days;

	modport source (
		output valid, req_type, year_in, month_in, day_in, serial_in, offset_days,
		input  ready
	);

	modport sink (
		input  valid, req_type, year_in, month_in, day_in, serial_in, offset_days,
		output ready
	);

endinterface

[sv/cddn_rsp_if.sv]
// ----------------------------------------------------------------------------
// cddn_rsp_if - result channel
// Valid/ready channel carrying one conversion result per transaction.
// ----------------------------------------------------------------------------
interface cddn_rsp_if;

	logic        valid;
	logic        ready;
	logic [11:0] year_out;
	logic [3:0]  month_out;
	logic [4:0]  day_out;
	logic [14:0] serial_out;
	logic        invalid;

	modport source (
		output valid, year_out, month_out, day_out, serial_out, invalid,
		input  ready
	);

	modport sink (
		input  valid, year_out, month_out, day_out, serial_out, invalid,
		output ready
	);

endinterface

[sv/cddn_month_split.sv]
// ----------------------------------------------------------------------------
// cddn_month_split - day of year to month and day
// Compares the zero-based day of year against all month starts in parallel
// and forms the month and the day of month.
// ----------------------------------------------------------------------------
module cddn_month_split (
	input  logic                   [8:0] rem,
	input  logic                         leap,
	output cddn_pkg::month_day_t         md
);

	logic [3:0] month;
	logic [8:0] day_w;

	// count the month starts at or below the day of year
	always_comb begin
		month = 4'd1;
		for (int j = 2; j <= int'(cddn_pkg::MONTHS_PER_YEAR); j++) begin
			if (rem >= cddn_pkg::days_before_month(4'(j), leap))
				month = month + 4'd1;
		end
		day_w = rem - cddn_pkg::days_before_month(month, leap) + 9'd1;
	end

	assign md.month = month;
	assign md.day   = day_w[4:0];

endmodule

[sv/calendar_date_day_number_converter.sv]
// ----------------------------------------------------------------------------
// calendar_date_day_number_converter - date / serial day number converter
// Six-stage pipeline converting dates to day numbers and back.
// ----------------------------------------------------------------------------
// Converts between calendar dates and a serial day number counted from
// January 1 of EPOCH_YEAR. Request 0 checks year, month and day and returns
// the day number with the date echoed; request 1 adds offset_days to
// serial_in and returns the date of the sum. Any out-of-range input gives a
// result with invalid set and all other fields zero. The block is a
// six-stage pipeline: one request can be accepted every cycle, limited
// only by the result side taking results. The year of a day number is
// found without iteration: an estimate from a divide-by-366 reciprocal
// multiply, then one correction step against the exact start of the
// following year.
// ----------------------------------------------------------------------------
module calendar_date_day_number_converter #(
	parameter int unsigned EPOCH_YEAR = cddn_pkg::EPOCH_YEAR_DEF,
	parameter int unsigned LAST_YEAR  = cddn_pkg::LAST_YEAR_DEF
) (
	input logic         clk,
	input logic         arst_n,
	cddn_req_if.sink    req,
	cddn_rsp_if.source  rsp
);

	localparam cddn_pkg::year_t EPOCH      = cddn_pkg::year_t'(EPOCH_YEAR);
	localparam cddn_pkg::year_t LAST       = cddn_pkg::year_t'(LAST_YEAR);
	localparam cddn_pkg::year_t EPOCH_PREV = EPOCH - 14'd1;
	localparam logic [11:0]     LEAPS_PRE  =
		cddn_pkg::leap_count(EPOCH_PREV, cddn_pkg::div100(EPOCH_PREV));
	localparam logic [8:0]      SPAN       = 9'(LAST_YEAR - EPOCH_YEAR);

	typedef struct packed {
		logic            req_type;
		cddn_pkg::year_t year;
		logic [6:0]      month;
		logic [6:0]      day;
		cddn_pkg::cent_t cent_cur;
		cddn_pkg::cent_t cent_prev;
		logic            neg;
		logic [15:0]     sum;
	} st1_t;

	typedef struct packed {
		logic            req_type;
		logic            ok0;
		cddn_pkg::year_t year;
		logic [3:0]      month;
		logic [4:0]      day;
		logic [9:0]      part;
		logic [11:0]     lc_prev;
		logic            neg;
		logic [15:0]     sum;
		logic [7:0]      kest;
	} st2_t;

	typedef struct packed {
		logic            req_type;
		logic            ok0;
		cddn_pkg::year_t year;
		logic [3:0]      month;
		logic [4:0]      day;
		logic [17:0]     serial0;
		logic            neg;
		logic [15:0]     sum;
		logic [7:0]      kest;
		cddn_pkg::year_t xyear;
		cddn_pkg::cent_t xcent;
	} st3_t;

	typedef struct packed {
		logic            req_type;
		logic            ok0;
		cddn_pkg::year_t year;
		logic [3:0]      month;
		logic [4:0]      day;
		logic [17:0]     serial0;
		logic            neg;
		logic [15:0]     sum;
		logic [7:0]      kest;
		logic [17:0]     start_next;
		logic            leap_x;
		logic            leap_x1;
	} st4_t;

	typedef struct packed {
		logic            req_type;
		logic            ok0;
		cddn_pkg::year_t year;
		logic [3:0]      month;
		logic [4:0]      day;
		logic [17:0]     serial0;
		logic            err1;
		logic [11:0]     year1;
		logic [8:0]      rem;
		logic            leap_y;
		logic [15:0]     sum;
	} st5_t;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [14:0] serial;
		logic        invalid;
	} st6_t;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;

	st1_t pipe_s1, nxt1;
	st2_t pipe_s2, nxt2;
	st3_t pipe_s3, nxt3;
	st4_t pipe_s4, nxt4;
	st5_t pipe_s5, nxt5;
	st6_t pipe_s6, nxt6;

	logic signed [16:0] sum_w;
	logic               leap_cur;
	logic [31:0]        kprod;
	logic [11:0]        lcx;
	logic [6:0]         xmod;
	cddn_pkg::cent_t    xcent1;
	logic [17:0]        s18;
	logic [17:0]        start_this;
	logic               ge;
	logic [8:0]         kyear;

	cddn_pkg::month_day_t md;

	// stall control, a stage moves when it is empty or its successor moves
	assign adv6 = !vld_s6 || rsp.ready;
	assign adv5 = !vld_s5 || adv6;
	assign adv4 = !vld_s4 || adv5;
	assign adv3 = !vld_s3 || adv4;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;
	assign req.ready = adv1;

	// stage 1: capture, full-precision sum, century numbers
	always_comb begin
		sum_w          = 17'(req.serial_in) + 17'(req.offset_days);
		nxt1.req_type  = req.req_type;
		nxt1.year      = req.year_in;
		nxt1.month     = req.month_in;
		nxt1.day       = req.day_in;
		nxt1.cent_cur  = cddn_pkg::div100(req.year_in);
		nxt1.cent_prev = cddn_pkg::div100(req.year_in - 14'd1);
		nxt1.neg       = sum_w[16];
		nxt1.sum       = sum_w[15:0];
	end

	// stage 2: date check, offset within year, year estimate
	always_comb begin
		leap_cur      = cddn_pkg::is_leap(pipe_s1.year, pipe_s1.cent_cur);
		kprod         = 32'(pipe_s1.sum) * 32'(cddn_pkg::DIV366_MUL);
		nxt2.req_type = pipe_s1.req_type;
		nxt2.ok0      = (pipe_s1.year >= EPOCH) && (pipe_s1.year <= LAST) &&
			(pipe_s1.month >= 7'd1) && (pipe_s1.month <= 7'(cddn_pkg::MONTHS_PER_YEAR)) &&
			(pipe_s1.day >= 7'd1) &&
			(pipe_s1.day <= 7'(cddn_pkg::month_days(pipe_s1.month[3:0], leap_cur)));
		nxt2.year     = pipe_s1.year;
		nxt2.month    = pipe_s1.month[3:0];
		nxt2.day      = pipe_s1.day[4:0];
		nxt2.part     = 10'(cddn_pkg::days_before_month(pipe_s1.month[3:0], leap_cur)) +
			10'(pipe_s1.day) - 10'd1;
		nxt2.lc_prev  = cddn_pkg::leap_count(pipe_s1.year - 14'd1, pipe_s1.cent_prev);
		nxt2.neg      = pipe_s1.neg;
		nxt2.sum      = pipe_s1.sum;
		nxt2.kest     = kprod[31:24];
	end

	// stage 3: day number of a date, century of the estimated year
	always_comb begin
		nxt3.req_type = pipe_s2.req_type;
		nxt3.ok0      = pipe_s2.ok0;
		nxt3.year     = pipe_s2.year;
		nxt3.month    = pipe_s2.month;
		nxt3.day      = pipe_s2.day;
		nxt3.serial0  = 18'(pipe_s2.year - EPOCH) * 18'(cddn_pkg::DAYS_PER_YEAR) +
			18'(pipe_s2.lc_prev) - 18'(LEAPS_PRE) + 18'(pipe_s2.part);
		nxt3.neg      = pipe_s2.neg;
		nxt3.sum      = pipe_s2.sum;
		nxt3.kest     = pipe_s2.kest;
		nxt3.xyear    = EPOCH + cddn_pkg::year_t'(pipe_s2.kest);
		nxt3.xcent    = cddn_pkg::div100(EPOCH + cddn_pkg::year_t'(pipe_s2.kest));
	end

	// stage 4: start of the year after the estimate, leap flags of both years
	always_comb begin
		lcx             = cddn_pkg::leap_count(pipe_s3.xyear, pipe_s3.xcent);
		xmod            = cddn_pkg::mod100(pipe_s3.xyear, pipe_s3.xcent);
		xcent1          = pipe_s3.xcent + ((xmod == 7'd99) ? 8'd1 : 8'd0);
		nxt4.req_type   = pipe_s3.req_type;
		nxt4.ok0        = pipe_s3.ok0;
		nxt4.year       = pipe_s3.year;
		nxt4.month      = pipe_s3.month;
		nxt4.day        = pipe_s3.day;
		nxt4.serial0    = pipe_s3.serial0;
		nxt4.neg        = pipe_s3.neg;
		nxt4.sum        = pipe_s3.sum;
		nxt4.kest       = pipe_s3.kest;
		nxt4.start_next = 18'({1'b0, pipe_s3.kest} + 9'd1) * 18'(cddn_pkg::DAYS_PER_YEAR) +
			18'(lcx) - 18'(LEAPS_PRE);
		nxt4.leap_x     = cddn_pkg::is_leap(pipe_s3.xyear, pipe_s3.xcent);
		nxt4.leap_x1    = cddn_pkg::is_leap(pipe_s3.xyear + 14'd1, xcent1);
	end

	// stage 5: correct the year estimate, day of year, range check
	always_comb begin
		s18           = 18'(pipe_s4.sum);
		ge            = (s18 >= pipe_s4.start_next);
		start_this    = pipe_s4.start_next - 18'(cddn_pkg::DAYS_PER_YEAR) -
			18'(pipe_s4.leap_x);
		kyear         = ge ? ({1'b0, pipe_s4.kest} + 9'd1) : {1'b0, pipe_s4.kest};
		nxt5.req_type = pipe_s4.req_type;
		nxt5.ok0      = pipe_s4.ok0;
		nxt5.year     = pipe_s4.year;
		nxt5.month    = pipe_s4.month;
		nxt5.day      = pipe_s4.day;
		nxt5.serial0  = pipe_s4.serial0;
		nxt5.err1     = pipe_s4.neg || (kyear > SPAN);
		nxt5.year1    = 12'(EPOCH + cddn_pkg::year_t'(kyear));
		nxt5.rem      = 9'(s18 - (ge ? pipe_s4.start_next : start_this));
		nxt5.leap_y   = ge ? pipe_s4.leap_x1 : pipe_s4.leap_x;
		nxt5.sum      = pipe_s4.sum;
	end

	cddn_month_split u_month_split (
		.rem  (pipe_s5.rem),
		.leap (pipe_s5.leap_y),
		.md   (md)
	);

	// stage 6: month split and result select, zero fields on error
	always_comb begin
		nxt6 = '0;
		if (pipe_s5.req_type == cddn_pkg::REQ_DATE_TO_SERIAL) begin
			if (pipe_s5.ok0) begin
				nxt6.year   = pipe_s5.year[11:0];
				nxt6.month  = pipe_s5.month;
				nxt6.day    = pipe_s5.day;
				nxt6.serial = pipe_s5.serial0[14:0];
			end else begin
				nxt6.invalid = 1'b1;
			end
		end else begin
			if (!pipe_s5.err1) begin
				nxt6.year   = pipe_s5.year1;
				nxt6.month  = md.month;
				nxt6.day    = md.day;
				nxt6.serial = pipe_s5.sum[14:0];
			end else begin
				nxt6.invalid = 1'b1;
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= req.valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
			if (adv5) vld_s5 <= vld_s4;
			if (adv6) vld_s6 <= vld_s5;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv1) pipe_s1 <= nxt1;
		if (adv2) pipe_s2 <= nxt2;
		if (adv3) pipe_s3 <= nxt3;
		if (adv4) pipe_s4 <= nxt4;
		if (adv5) pipe_s5 <= nxt5;
		if (adv6) pipe_s6 <= nxt6;
	end

	assign rsp.valid      = vld_s6;
	assign rsp.year_out   = pipe_s6.year;
	assign rsp.month_out  = pipe_s6.month;
	assign rsp.day_out    = pipe_s6.day;
	assign rsp.serial_out = pipe_s6.serial;
	assign rsp.invalid    = pipe_s6.invalid;

endmodule

[test/calendar_date_day_number_converter_tb.sv]
// ----------------------------------------------------------------------------
// calendar_date_day_number_converter_tb - self-checking date converter bench
// Drives date and day-number requests through the request channel with
// random gaps and random result back-pressure. A table of corner cases runs
// first, then random traffic. Every result is compared, in order, against
// a typed expectation or an in-bench calendar model.
// ----------------------------------------------------------------------------
module calendar_date_day_number_converter_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned EPOCH = cddn_pkg::EPOCH_YEAR_DEF;
	localparam int unsigned LAST  = cddn_pkg::LAST_YEAR_DEF;
	localparam int unsigned RANDOM_ITEMS = 1750;
	localparam int unsigned MAX_REPORTS  = 10;

	typedef struct packed {
		cddn_pkg::req_kind_t kind;
		logic [13:0]         year;
		logic [6:0]          month;
		logic [6:0]          day;
		logic signed [15:0]  serial;
		logic signed [15:0]  offset;
	} date_req_t;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [14:0] serial;
		logic        invalid;
	} date_rsp_t;

	typedef struct {
		date_req_t req;
		bit        known;
		date_rsp_t want;
	} dir_row_t;

	localparam date_rsp_t OUT_OF_RANGE = '{year: '0, month: '0, day: '0, serial: '0,
		invalid: 1'b1};

	logic clk;
	logic arst_n;

	cddn_req_if req_ch ();
	cddn_rsp_if rsp_ch ();

	calendar_date_day_number_converter #(
		.EPOCH_YEAR(EPOCH),
		.LAST_YEAR (LAST)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	date_rsp_t   conversions_due [$];
	bit          steady_flow;
	int unsigned fail_count;
	int unsigned n_date_reqs;
	int unsigned n_serial_reqs;
	int unsigned n_checked;
	int unsigned n_flagged;
	dir_row_t    directed [24];

	// calendar arithmetic
	function automatic bit leap_year(int unsigned y);
		return (y % 4 == 0) && (y % 4000 != 0) && ((y % 400 == 0) || (y % 100 != 0));
	endfunction

	function automatic int unsigned year_length(int unsigned y);
		return leap_year(y) ? 366 : 365;
	endfunction

	function automatic int unsigned month_length(int unsigned y, int unsigned m);
		case (m)
			2: return leap_year(y) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default: return 31;
		endcase
	endfunction

	function automatic int unsigned day_number(int unsigned y, int unsigned m,
		int unsigned d);
		int unsigned n;
		n = 0;
		for (int unsigned i = EPOCH; i < y; i++)
			n += year_length(i);
		for (int unsigned i = 1; i < m; i++)
			n += month_length(y, i);
		return n + d - 1;
	endfunction

	// expected result of one request
	function automatic date_rsp_t convert_request(date_req_t r);
		date_rsp_t   res;
		int unsigned y;
		int unsigned m;
		int unsigned d;
		int          sum;
		int unsigned rest;
		res = OUT_OF_RANGE;
		if (r.kind == cddn_pkg::REQ_DATE_TO_SERIAL) begin
			y = r.year;
			m = r.month;
			d = r.day;
			if (y < EPOCH || y > LAST || m < 1 || m > 12 || d < 1)
				return res;
			if (d > month_length(y, m))
				return res;
			res.serial = 15'(day_number(y, m, d));
		end else begin
			sum = int'(r.serial) + int'(r.offset);
			if (sum < 0 || sum > int'(day_number(LAST, 12, 31)))
				return res;
			rest = sum;
			y = EPOCH;
			while (rest >= year_length(y)) begin
				rest -= year_length(y);
				y++;
			end
			m = 1;
			while (m < 12 && rest >= month_length(y, m)) begin
				rest -= month_length(y, m);
				m++;
			end
			d = rest + 1;
			res.serial = 15'(sum);
		end
		res.year    = 12'(y);
		res.month   = 4'(m);
		res.day     = 5'(d);
		res.invalid = 1'b0;
		return res;
	endfunction

	function automatic date_req_t mk_req(cddn_pkg::req_kind_t k, int unsigned y,
		int unsigned m, int unsigned d, int s, int o);
		date_req_t r;
		r.kind   = k;
		r.year   = 14'(y);
		r.month  = 7'(m);
		r.day    = 7'(d);
		r.serial = 16'(s);
		r.offset = 16'(o);
		return r;
	endfunction

	function automatic date_rsp_t rsp_ok(int unsigned y, int unsigned m, int unsigned d,
		int unsigned s);
		date_rsp_t res;
		res.year    = 12'(y);
		res.month   = 4'(m);
		res.day     = 5'(d);
		res.serial  = 15'(s);
		res.invalid = 1'b0;
		return res;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned p;
		if (steady_flow)
			return 0;
		p = $urandom_range(99);
		if (p < 50)
			return 0;
		if (p < 85)
			return $urandom_range(3, 1);
		if (p < 97)
			return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	// random request, mostly well-formed with noise in the unused fields
	function automatic date_req_t random_request();
		date_req_t   r;
		int unsigned p;
		int unsigned y;
		int unsigned m;
		int unsigned d;
		int          target;
		int          lo;
		int          hi;
		int          off;
		r.kind   = cddn_pkg::REQ_DATE_TO_SERIAL;
		r.year   = 14'($urandom);
		r.month  = 7'($urandom);
		r.day    = 7'($urandom);
		r.serial = 16'($urandom);
		r.offset = 16'($urandom);
		p = $urandom_range(99);
		if (p < 40) begin
			// legal date, often on a month edge
			y = $urandom_range(LAST, EPOCH);
			m = $urandom_range(12, 1);
			d = $urandom_range(month_length(y, m), 1);
			if ($urandom_range(3) == 0)
				d = (d <= 15) ? 1 : month_length(y, m);
			r.year  = 14'(y);
			r.month = 7'(m);
			r.day   = 7'(d);
		end else if (p < 50) begin
			// just around the legal date range
			y = $urandom_range(LAST + 1, EPOCH - 1);
			m = $urandom_range(13, 0);
			d = $urandom_range(32, 0);
			if (m >= 1 && m <= 12 && $urandom_range(1) == 1)
				d = month_length(y, m) + 1;
			r.year  = 14'(y);
			r.month = 7'(m);
			r.day   = 7'(d);
		end else if (p < 58) begin
			// raw fields as drawn
		end else if (p < 92) begin
			r.kind = cddn_pkg::REQ_SERIAL_TO_DATE;
			if ($urandom_range(3) == 0)
				target = int'(day_number($urandom_range(LAST, EPOCH),
					$urandom_range(12, 1), 1)) - int'($urandom_range(1));
			else
				target = int'($urandom_range(day_number(LAST, 12, 31) + 3, 0)) - 3;
			if (target >= 0 && $urandom_range(2) == 0) begin
				r.serial = 16'(target);
				r.offset = '0;
			end else begin
				// split the sum over serial and offset, both in 16-bit range
				lo = (target - 32767 > -32768) ? target - 32767 : -32768;
				hi = (target + 32768 < 32767) ? target + 32768 : 32767;
				off = int'($urandom_range(hi + 32768, lo + 32768)) - 32768;
				r.offset = 16'(off);
				r.serial = 16'(target - off);
			end
		end else begin
			r.kind = cddn_pkg::REQ_SERIAL_TO_DATE;
		end
		return r;
	endfunction

	task automatic note_failure(string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("[%0t] ERROR: %s", $realtime, msg);
	endtask

	// one transaction on the request channel
	task automatic send_request(date_req_t r, date_rsp_t want);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.req_type    <= r.kind;
		req_ch.year_in     <= r.year;
		req_ch.month_in    <= r.month;
		req_ch.day_in      <= r.day;
		req_ch.serial_in   <= r.serial;
		req_ch.offset_days <= r.offset;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		conversions_due.push_back(want);
		if (r.kind == cddn_pkg::REQ_DATE_TO_SERIAL)
			n_date_reqs++;
		else
			n_serial_reqs++;
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		#10ms;
		$display("calendar_date_day_number_converter_tb: FAIL");
		$finish;
	end

	// result sink with random back-pressure, checks in order
	initial begin
		int unsigned stall_left;
		date_rsp_t   got;
		date_rsp_t   want;
		stall_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				got = '{rsp_ch.year_out, rsp_ch.month_out, rsp_ch.day_out,
					rsp_ch.serial_out, rsp_ch.invalid};
				n_checked++;
				if (got.invalid)
					n_flagged++;
				if (conversions_due.size() == 0) begin
					note_failure($sformatf("unexpected result y=%0d m=%0d d=%0d s=%0d inv=%0b",
						got.year, got.month, got.day, got.serial, got.invalid));
				end else begin
					want = conversions_due.pop_front();
					if (got.year !== want.year || got.month !== want.month ||
						got.day !== want.day || got.serial !== want.serial ||
						got.invalid !== want.invalid)
						note_failure($sformatf({"mismatch exp y=%0d m=%0d d=%0d s=%0d inv=%0b",
							" got y=%0d m=%0d d=%0d s=%0d inv=%0b"},
							want.year, want.month, want.day, want.serial, want.invalid,
							got.year, got.month, got.day, got.serial, got.invalid));
				end
			end
			if (!arst_n) begin
				rsp_ch.ready <= 1'b0;
			end else if (steady_flow) begin
				stall_left = 0;
				rsp_ch.ready <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				if ($urandom_range(9) < 3)
					stall_left = pick_gap();
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// reset, directed table, random traffic, drain
	initial begin
		steady_flow   = 1'b0;
		fail_count    = 0;
		n_date_reqs   = 0;
		n_serial_reqs = 0;
		n_checked     = 0;
		n_flagged     = 0;

		arst_n             <= 1'b0;
		req_ch.valid       <= 1'b0;
		req_ch.req_type    <= cddn_pkg::REQ_DATE_TO_SERIAL;
		req_ch.year_in     <= '0;
		req_ch.month_in    <= '0;
		req_ch.day_in      <= '0;
		req_ch.serial_in   <= '0;
		req_ch.offset_days <= '0;

		directed = '{
			'{mk_req(cddn_pkg::REQ_DATE_TO_SERIAL, 1996, 1, 1, 0, 0), 1,
				rsp_ok(1996, 1, 1, 0)},
			'{mk_req(cddn_pkg::REQ_DATE_TO_SERIAL, 2050, 12, 31, -1, 32767), 1,
				rsp_ok(2050, 12, 31, 20088)},
			'{mk_req(cddn_pkg::REQ_DATE_TO_SERIAL, 1995, 12, 31, 0, 0), 1, OUT_OF_RANGE},
			'{mk_req(cddn_pkg::REQ_DATE_TO_SERIAL, 2051, 1, 1, 0, 0), 1, OUT_OF_RANGE},
			'{mk_req(cddn_pkg::REQ_DATE_TO_SERIAL, 2000, 2, 29, 0, 0), 0, OUT_OF_RANGE},
			'{mk_req(cddn_pkg::REQ_DATE_TO_SERIAL, 1996, 2, 29, 0, 0), 0, OUT_OF_RANGE},
			'{mk_req(cddn_pkg::REQ_DATE_TO_SERIAL, 1999, 2, 29, 0, 0), 1, OUT_OF_RANGE},
			'{mk_req(cddn_pkg::REQ_DATE_TO_SERIAL, 2048, 2, 29, 0, 0), 0, OUT_OF_RANGE},
			'{mk_req(cddn_pkg::REQ_DATE_TO_SERIAL, 2024, 0, 10, 0, 0), 1, OUT_OF_RANGE},
			'{mk_req(cddn_pkg::REQ_DATE_TO_SERIAL, 2024, 13, 1, 0, 0), 1, OUT_OF_RANGE},
			'{mk_req(cddn_pkg::REQ_DATE_TO_SERIAL, 2024, 5, 0, 0, 0), 1, OUT_OF_RANGE},
			'{mk_req(cddn_pkg::REQ_DATE_TO_SERIAL, 2024, 1, 32, 0, 0), 1, OUT_OF_RANGE},
			'{mk_req(cddn_pkg::REQ_DATE_TO_SERIAL, 2024, 4, 31, 0, 0), 1, OUT_OF_RANGE},
			'{mk_req(cddn_pkg::REQ_DATE_TO_SERIAL, 16383, 127, 127, -32768, -32768), 1,
				OUT_OF_RANGE},
			'{mk_req(cddn_pkg::REQ_DATE_TO_SERIAL, 0, 0, 0, 0, 0), 1, OUT_OF_RANGE},
			'{mk_req(cddn_pkg::REQ_SERIAL_TO_DATE, 16383, 127, 127, 0, 0), 1,
				rsp_ok(1996, 1, 1, 0)},
			'{mk_req(cddn_pkg::REQ_SERIAL_TO_DATE, 0, 0, 0, 20088, 0), 1,
				rsp_ok(2050, 12, 31, 20088)},
			'{mk_req(cddn_pkg::REQ_SERIAL_TO_DATE, 0, 0, 0, 20089, 0), 1, OUT_OF_RANGE},
			'{mk_req(cddn_pkg::REQ_SERIAL_TO_DATE, 0, 0, 0, 0, -1), 1, OUT_OF_RANGE},
			'{mk_req(cddn_pkg::REQ_SERIAL_TO_DATE, 0, 0, 0, -32768, -32768), 1,
				OUT_OF_RANGE},
			'{mk_req(cddn_pkg::REQ_SERIAL_TO_DATE, 0, 0, 0, 32767, 32767), 1, OUT_OF_RANGE},
			'{mk_req(cddn_pkg::REQ_SERIAL_TO_DATE, 0, 0, 0, -20000, 30000), 0, OUT_OF_RANGE},
			'{mk_req(cddn_pkg::REQ_SERIAL_TO_DATE, 0, 0, 0, 1461, 59), 0, OUT_OF_RANGE},
			'{mk_req(cddn_pkg::REQ_SERIAL_TO_DATE, 0, 0, 0, 10000, 10088), 1,
				rsp_ok(2050, 12, 31, 20088)}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner cases, typed expectation where obvious
		foreach (directed[i])
			send_request(directed[i].req,
				directed[i].known ? directed[i].want : convert_request(directed[i].req));

		// random traffic, every fourth stretch without any idling
		for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
			date_req_t r;
			steady_flow = ((i / 150) % 4 == 3);
			r = random_request();
			send_request(r, convert_request(r));
		end
		steady_flow = 1'b0;
		req_ch.valid <= 1'b0;

		// drain the pipeline
		while (conversions_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display({"covered %0d date-to-day and %0d day-to-date transactions,",
			" %0d of them corner cases"},
			n_date_reqs, n_serial_reqs, $size(directed));
		$display("%0d results checked, %0d flagged out of range, %0d failures",
			n_checked, n_flagged, fail_count);
		if (fail_count == 0)
			$display("calendar_date_day_number_converter_tb: PASS");
		else
			$display("calendar_date_day_number_converter_tb: FAIL");
		$finish;
	end

endmodule
